@@ rtl/byte_alu_with_flags_unit_defines.svh @@
// Assertion macros for the byte ALU.
`ifndef BYTE_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define BYTE_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

// An implication checked on every clock edge outside reset.
`define BAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// An implication whose consequent is checked in the cycle after its antecedent.
`define BAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/baf_pkg.sv @@
`default_nettype none
package baf_pkg;
  localparam int unsigned DivBits = 16;
  localparam int unsigned DivStages = 4;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_ADC = 5'd1, OP_SUB = 5'd2, OP_SBC = 5'd3, OP_CMP = 5'd4,
    OP_AND = 5'd5, OP_BIT = 5'd6, OP_EOR = 5'd7, OP_ORA = 5'd8, OP_ASR = 5'd9,
    OP_LSR = 5'd10, OP_ROR = 5'd11, OP_LSL = 5'd12, OP_ROL = 5'd13,
    OP_COM = 5'd14, OP_NEG = 5'd15, OP_INC = 5'd16, OP_DEC = 5'd17,
    OP_CLR = 5'd18, OP_TST = 5'd19, OP_DAA = 5'd20, OP_MUL = 5'd21,
    OP_DIV = 5'd22
  } func_t;

  localparam logic [4:0] MaskV = 5'b10000;
  localparam logic [4:0] MaskH = 5'b01000;
  localparam logic [4:0] MaskN = 5'b00100;
  localparam logic [4:0] MaskZ = 5'b00010;
  localparam logic [4:0] MaskC = 5'b00001;

  typedef struct packed {
    logic [4:0] func;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [7:0] index_low;
    logic [7:0] index_high;
    logic       carry_in;
    logic       half_carry_in;
  } item_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] result_high;
    logic       write_result;
    logic       write_high;
    logic       flag_v;
    logic       flag_h;
    logic       flag_n;
    logic       flag_z;
    logic       flag_c;
    logic [4:0] flag_mask;
  } res_t;

  // State of one division stage: partial remainder and quotient so far.
  typedef struct packed {
    logic [8:0]  rem;
    logic [15:0] quo;
  } div_t;
endpackage
`default_nettype wire

@@ rtl/baf_if.sv @@
`default_nettype none
interface baf_in_if import baf_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface baf_out_if import baf_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/baf_alu.sv @@
`default_nettype none
// Combinational logic for every operation except MUL and DIV.
module baf_alu import baf_pkg::*; (
  input  item_t it,
  output res_t  res
);
  logic [8:0] sum;
  logic [4:0] hsum;
  logic [8:0] diff;
  logic       ci;
  logic [7:0] a, m, r, f;
  logic       v, h, c, hic, loc;

  always_comb begin
    a = it.acc;
    m = it.operand;
    ci = 1'b0;
    res = '0;
    r = '0; v = 1'b0; h = 1'b0; c = 1'b0; f = '0;
    sum = '0; hsum = '0; diff = '0; hic = 1'b0; loc = 1'b0;
    unique case (it.func)
      OP_ADD, OP_ADC: begin
        ci = (it.func == OP_ADC) ? it.carry_in : 1'b0;
        sum = {1'b0, a} + {1'b0, m} + {8'd0, ci};
        hsum = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, ci};
        r = sum[7:0];
        c = sum[8];
        h = hsum[4];
        v = ~(a[7] ^ m[7]) & (a[7] ^ r[7]);
        res.write_result = 1'b1;
        res.flag_mask = MaskV | MaskH | MaskN | MaskZ | MaskC;
      end
      OP_SUB, OP_SBC, OP_CMP: begin
        ci = (it.func == OP_SBC) ? it.carry_in : 1'b0;
        diff = {1'b0, a} - {1'b0, m} - {8'd0, ci};
        r = diff[7:0];
        c = diff[8];
        v = (a[7] ^ m[7]) & (a[7] ^ r[7]);
        res.write_result = (it.func != OP_CMP);
        res.flag_mask = MaskV | MaskN | MaskZ | MaskC;
      end
      OP_AND, OP_BIT: begin
        r = a & m;
        res.write_result = (it.func == OP_AND);
        res.flag_mask = MaskV | MaskN | MaskZ;
      end
      OP_EOR: begin
        r = a ^ m; res.write_result = 1'b1; res.flag_mask = MaskV | MaskN | MaskZ;
      end
      OP_ORA: begin
        r = a | m; res.write_result = 1'b1; res.flag_mask = MaskV | MaskN | MaskZ;
      end
      OP_ASR, OP_LSR, OP_ROR: begin
        c = m[0];
        r = {(it.func == OP_ASR) ? m[7] : ((it.func == OP_ROR) ? it.carry_in : 1'b0),
             m[7:1]};
        v = r[7] ^ c;
        res.write_result = 1'b1;
        res.flag_mask = MaskV | MaskN | MaskZ | MaskC;
      end
      OP_LSL, OP_ROL: begin
        c = m[7];
        r = {m[6:0], (it.func == OP_ROL) ? it.carry_in : 1'b0};
        v = r[7] ^ c;
        res.write_result = 1'b1;
        res.flag_mask = MaskV | MaskN | MaskZ | MaskC;
      end
      OP_COM: begin
        r = ~m; c = 1'b1; res.write_result = 1'b1;
        res.flag_mask = MaskV | MaskN | MaskZ | MaskC;
      end
      OP_NEG: begin
        r = 8'd0 - m; c = (r != 8'd0); v = r[7] & m[7];
        res.write_result = 1'b1;
        res.flag_mask = MaskV | MaskN | MaskZ | MaskC;
      end
      OP_INC: begin
        r = m + 8'd1; v = (m == 8'h7F); res.write_result = 1'b1;
        res.flag_mask = MaskV | MaskN | MaskZ;
      end
      OP_DEC: begin
        r = m - 8'd1; v = (m == 8'h80); res.write_result = 1'b1;
        res.flag_mask = MaskV | MaskN | MaskZ;
      end
      OP_CLR: begin
        r = 8'd0; res.write_result = 1'b1; res.flag_mask = MaskV | MaskN | MaskZ;
      end
      OP_TST: begin
        r = m; res.flag_mask = MaskV | MaskN | MaskZ;
      end
      OP_DAA: begin
        loc = it.half_carry_in || (a[3:0] > 4'd9);
        hic = it.carry_in || (a[7:4] > 4'd9) || ((a[7:4] >= 4'd9) && (a[3:0] > 4'd9));
        f = {1'b0, hic, hic, 2'b00, loc, loc, 1'b0};
        r = a + f;
        c = it.carry_in | hic;
        res.write_result = 1'b1;
        res.flag_mask = MaskN | MaskZ | MaskC;
      end
      default: begin
      end
    endcase
    res.result = r;
    res.flag_v = v & res.flag_mask[4];
    res.flag_h = h & res.flag_mask[3];
    res.flag_n = r[7] & res.flag_mask[2];
    res.flag_z = (r == 8'd0) & res.flag_mask[1];
    res.flag_c = c & res.flag_mask[0];
  end
endmodule
`default_nettype wire

@@ rtl/byte_alu_with_flags_unit.sv @@
`default_nettype none
// Channel  | Dir | Payload
// in_      | in  | func, acc, operand, index_low, index_high, carry_in, half_carry_in
// out_     | out | result, result_high, write/flags/mask
// One transaction per cycle in each direction while the output is not stalled;
// an accepted input passes the STAGES stage registers, then the output register.
// STAGES register stages of restoring division share the DivBits quotient bits.
// The multiply sits in the first stage; the other ops but DIV are decoded there too.
// A stall holds the whole pipe; the output register is freed when taken.
// Synchronous active-low reset clears the valid bits only.
`include "byte_alu_with_flags_unit_defines.svh"
module byte_alu_with_flags_unit import baf_pkg::*; #(
  parameter int unsigned STAGES = DivStages
) (
  input wire logic clk,
  input wire logic rst_n,
  baf_in_if.sink   in_ch,
  baf_out_if.source out_ch
);
  localparam int unsigned StepBits = DivBits / STAGES;
  // The last stage takes whatever quotient bits the earlier ones leave.
  localparam int unsigned LastBits = DivBits - (STAGES - 1) * StepBits;

  item_t it_r [STAGES];
  res_t  res_r [STAGES];
  div_t  dv_r [STAGES];
  logic  vld_r [STAGES];
  logic  out_vld_r;
  res_t  out_r;
  logic  adv;
  res_t  alu_res;
  logic [15:0] prod;

  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_r;

  baf_alu u_alu (.it(in_ch.data), .res(alu_res));
  assign prod = {8'd0, in_ch.data.acc} * {8'd0, in_ch.data.index_low};

  // One restoring step: shift in the next dividend bit, try to subtract.
  function automatic div_t div_step(div_t d, logic [7:0] x);
    logic [8:0] t;
    logic [9:0] s;
    div_t       o;
    t = {d.rem[7:0], d.quo[15]};
    s = {1'b0, t} - {2'b00, x};
    o.quo = {d.quo[14:0], !s[9]};
    o.rem = s[9] ? t : s[8:0];
    return o;
  endfunction

  function automatic div_t div_run(div_t d, logic [7:0] x, int unsigned n);
    div_t w;
    w = d;
    for (int i = 0; i < n; i++) w = div_step(w, x);
    return w;
  endfunction

  res_t s0_res;
  always_comb begin
    s0_res = alu_res;
    if (in_ch.data.func == OP_MUL) begin
      s0_res = '0;
      s0_res.result = prod[7:0];
      s0_res.result_high = prod[15:8];
      s0_res.write_result = 1'b1;
      s0_res.write_high = 1'b1;
      s0_res.flag_mask = MaskH | MaskC;
    end else if (in_ch.data.func == OP_DIV) begin
      s0_res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) vld_r[k] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < STAGES; k++) vld_r[k] <= vld_r[k-1];
      out_vld_r <= vld_r[STAGES-1];
    end
  end

  res_t fin;
  div_t dlast;
  always_comb begin
    dlast = div_run(dv_r[STAGES-1], it_r[STAGES-1].index_low, LastBits);
    fin = res_r[STAGES-1];
    if (it_r[STAGES-1].func == OP_DIV) begin
      fin = '0;
      fin.flag_mask = MaskC;
      fin.flag_c = 1'b1;
      if (it_r[STAGES-1].index_low != 8'd0) begin
        fin.result = dlast.quo[7:0];
        fin.result_high = dlast.rem[7:0];
        fin.write_result = 1'b1;
        fin.write_high = 1'b1;
        fin.flag_mask = MaskZ | MaskC;
        fin.flag_c = (dlast.quo[15:8] != 8'd0);
        fin.flag_z = (dlast.quo == 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_r[0] <= in_ch.data;
      res_r[0] <= s0_res;
      dv_r[0] <= '{rem: 9'd0, quo: {in_ch.data.index_high, in_ch.data.acc}};
      for (int k = 1; k < STAGES; k++) begin
        it_r[k] <= it_r[k-1];
        res_r[k] <= res_r[k-1];
        dv_r[k] <= div_run(dv_r[k-1], it_r[k-1].index_low, StepBits);
      end
      out_r <= fin;
    end
  end

  `BAF_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
  `BAF_ASSERT_IMP(a_rdy, clk, rst_n, !out_vld_r, in_ch.ready)
  `BAF_ASSERT_IMP(a_wh, clk, rst_n, out_ch.valid && out_ch.data.write_high,
                  out_ch.data.write_result)
endmodule
`default_nettype wire
